[rtl/core/slid_pkg.sv]
package slid_pkg;

  // Table size and the widths that follow from it.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Fixed field widths of the transactions.
  localparam int unsigned CMD_W = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned ENTRY_COUNT_W = 5;

  // Common width for comparing a requested index against the fill count.
  localparam int unsigned CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  // Command codes. Any code with the high bit set reads an entry.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DELETED   = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_READ_OK   = 3'd4,
    STAT_BAD_INDEX = 3'd5
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } in_item_t;

  typedef struct packed {
    status_e status;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic signed [VALUE_W-1:0] read_value;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  // Update strobes shared by every cell of the table.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

[rtl/core/slid_cell.sv]
module slid_cell (
  input  logic                                 clk_i,
  input  slid_pkg::cell_ctl_t                  ctl_i,
  input  logic signed [slid_pkg::VALUE_W-1:0]  value_i,
  input  logic                                 valid_i,
  input  logic                                 left_lt_i,
  input  logic signed [slid_pkg::VALUE_W-1:0]  left_entry_i,
  input  logic signed [slid_pkg::VALUE_W-1:0]  right_entry_i,
  output logic signed [slid_pkg::VALUE_W-1:0]  entry_o,
  output logic                                 lt_o,
  output logic                                 eq_o
);

  logic signed [slid_pkg::VALUE_W-1:0] entry_q, entry_d;

  // Local comparisons; an empty slot counts as neither smaller nor equal.
  assign lt_o = valid_i && (entry_q < value_i);
  assign eq_o = valid_i && (entry_q == value_i);
  assign entry_o = entry_q;

  // An insert takes the new value where the left neighbour is smaller and
  // this entry is not, and shifts right beyond that point. A delete pulls
  // the right neighbour in from the first entry that is not smaller.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins && !lt_o) begin
      entry_d = left_lt_i ? value_i : left_entry_i;
    end else if (ctl_i.del && !lt_o) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

[rtl/core/slid_datapath.sv]
module slid_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slid_pkg::ctrl_cmd_t  cmd_i,
  input  slid_pkg::in_item_t   in_item_i,
  output slid_pkg::out_item_t  out_item_o
);

  logic [slid_pkg::CMD_W-1:0]          cmd_q;
  logic signed [slid_pkg::VALUE_W-1:0] value_q;
  logic [slid_pkg::INDEX_W-1:0]        index_q;
  logic [slid_pkg::CNT_W-1:0]          count_q, count_d;
  slid_pkg::out_item_t                 res_q, res_d;
  slid_pkg::cell_ctl_t                 cell_ctl;

  logic signed [slid_pkg::VALUE_W-1:0] entries [slid_pkg::CAPACITY];
  logic [slid_pkg::CAPACITY-1:0]       lt_vec;
  logic [slid_pkg::CAPACITY-1:0]       eq_vec;
  logic                                full;
  logic                                found;
  logic                                in_range;
  logic [slid_pkg::IDX_W-1:0]          rd_idx;

  // Operand registers, loaded when a transaction is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= in_item_i.command;
      value_q <= in_item_i.value;
      index_q <= in_item_i.index;
    end
  end

  // Row of compare and shift cells holding the sorted table.
  for (genvar i = 0; i < slid_pkg::CAPACITY; i++) begin : g_cell
    logic                                valid;
    logic                                left_lt;
    logic signed [slid_pkg::VALUE_W-1:0] left_entry;
    logic signed [slid_pkg::VALUE_W-1:0] right_entry;

    assign valid = slid_pkg::CNT_W'(i) < count_q;

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_entry = value_q;
    end else begin : g_inner
      assign left_lt    = lt_vec[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == slid_pkg::CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_body
      assign right_entry = entries[i+1];
    end

    slid_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (cell_ctl),
      .value_i      (value_q),
      .valid_i      (valid),
      .left_lt_i    (left_lt),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .entry_o      (entries[i]),
      .lt_o         (lt_vec[i]),
      .eq_o         (eq_vec[i])
    );
  end

  assign full     = count_q == slid_pkg::CNT_W'(slid_pkg::CAPACITY);
  assign found    = |eq_vec;
  assign in_range = slid_pkg::CMP_W'(index_q) < slid_pkg::CMP_W'(count_q);
  assign rd_idx   = slid_pkg::IDX_W'(index_q);

  // Decode the command, steer the cells and form the result.
  always_comb begin
    cell_ctl.ins = 1'b0;
    cell_ctl.del = 1'b0;
    count_d      = count_q;
    res_d.status = slid_pkg::STAT_BAD_INDEX;
    res_d.read_value = '0;
    if (cmd_q == slid_pkg::CMD_INSERT) begin
      if (full) begin
        res_d.status = slid_pkg::STAT_FULL;
      end else begin
        cell_ctl.ins = cmd_i.exec;
        count_d      = count_q + slid_pkg::CNT_W'(1);
        res_d.status = slid_pkg::STAT_INSERTED;
      end
    end else if (cmd_q == slid_pkg::CMD_DELETE) begin
      if (found) begin
        cell_ctl.del = cmd_i.exec;
        count_d      = count_q - slid_pkg::CNT_W'(1);
        res_d.status = slid_pkg::STAT_DELETED;
      end else begin
        res_d.status = slid_pkg::STAT_NOT_FOUND;
      end
    end else if (in_range) begin
      res_d.status     = slid_pkg::STAT_READ_OK;
      res_d.read_value = entries[rd_idx];
    end
    res_d.entry_count = slid_pkg::ENTRY_COUNT_W'(count_d);
  end

  // Fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  assign out_item_o = res_q;

endmodule

[rtl/core/slid_ctrl.sv]
module slid_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output slid_pkg::ctrl_cmd_t  cmd_o
);

  slid_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // The result register may be overwritten once it is empty or being taken.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slid_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = slid_pkg::ST_EXEC;
        end
      end
      slid_pkg::ST_EXEC: begin
        if (out_free) begin
          state_d = slid_pkg::ST_IDLE;
        end
      end
      default: state_d = slid_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall_o = 1'b1;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    unique case (state_q)
      slid_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      slid_pkg::ST_EXEC: begin
        cmd_o.exec = out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // Result valid flag: set by an update, cleared when the result is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slid_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/sorted_list_insert_delete_top.sv]
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i, in_stall_o | in_item_i (command, value, index)
// out     | output    | out_valid_o, out_stall_i | out_item_o (status, entry_count, read_value)
//
// Each command has two steps: one to capture the operands and one in which
// every cell of the table compares and shifts at once and the result is registered.
// The cell row updates every entry in that one step, whatever the capacity.
// Reset is asynchronous and active low; it empties the table by clearing the count.
// A held result stalls the update cycle, and with it the input, until it is taken.
module sorted_list_insert_delete_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  slid_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output slid_pkg::out_item_t  out_item_o
);

  slid_pkg::ctrl_cmd_t ctrl_cmd;

  slid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (ctrl_cmd)
  );

  slid_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (ctrl_cmd),
    .in_item_i (in_item_i),
    .out_item_o(out_item_o)
  );

  // One transaction at a time: input is held off right after an acceptance.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a transaction was in progress");

  // Every table update leaves a result waiting at the output.
  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.exec |=> out_valid_o)
    else $error("update completed without a result");

  // Only a successful read carries a non-zero value.
  a_read_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != slid_pkg::STAT_READ_OK
      |-> out_item_o.read_value == '0)
    else $error("read value set on a result that is not a read");

endmodule
